/* src/plm_pkg.sv */
// ----------------------------------------------------------------------------
// plm_pkg: shared types and codes of the pooled list manager
// Operation codes, cursor states, answer codes, datapath micro-op codes and
// the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package plm_pkg;

    // pool sizes; the handle and count port widths are sized for these
    localparam int NUM_NODES = 64;
    localparam int NUM_LISTS = 16;

    // operation codes of a request
    localparam logic [3:0] OP_CREATE     = 4'd0;
    localparam logic [3:0] OP_COUNT      = 4'd1;
    localparam logic [3:0] OP_FIRST      = 4'd2;
    localparam logic [3:0] OP_LAST       = 4'd3;
    localparam logic [3:0] OP_NEXT       = 4'd4;
    localparam logic [3:0] OP_PREV       = 4'd5;
    localparam logic [3:0] OP_CURRENT    = 4'd6;
    localparam logic [3:0] OP_INS_AFTER  = 4'd7;
    localparam logic [3:0] OP_INS_BEFORE = 4'd8;
    localparam logic [3:0] OP_APPEND     = 4'd9;
    localparam logic [3:0] OP_PREPEND    = 4'd10;
    localparam logic [3:0] OP_REMOVE     = 4'd11;
    localparam logic [3:0] OP_TRIM       = 4'd12;
    localparam logic [3:0] OP_CONCAT     = 4'd13;
    localparam logic [3:0] OP_FREE       = 4'd14;
    localparam logic [3:0] OP_SEARCH     = 4'd15;

    // cursor states
    localparam logic [1:0] CUR_EMPTY  = 2'd0;
    localparam logic [1:0] CUR_ON     = 2'd1;
    localparam logic [1:0] CUR_BEFORE = 2'd2;
    localparam logic [1:0] CUR_PAST   = 2'd3;

    // answer codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_ITEM   = 2'd1;
    localparam logic [1:0] ST_POOL_FULL = 2'd2;
    localparam logic [1:0] ST_NO_HEAD   = 2'd3;

    // datapath micro-ops
    localparam int UOP_W = 5;
    localparam logic [UOP_W-1:0] U_NOP      = 5'd0;
    localparam logic [UOP_W-1:0] U_CLR      = 5'd1;
    localparam logic [UOP_W-1:0] U_LOAD     = 5'd2;
    localparam logic [UOP_W-1:0] U_HEADA    = 5'd3;
    localparam logic [UOP_W-1:0] U_HEADB    = 5'd4;
    localparam logic [UOP_W-1:0] U_ST1      = 5'd5;
    localparam logic [UOP_W-1:0] U_ST2      = 5'd6;
    localparam logic [UOP_W-1:0] U_ST3      = 5'd7;
    localparam logic [UOP_W-1:0] U_CREATE   = 5'd8;
    localparam logic [UOP_W-1:0] U_TGT_END  = 5'd9;
    localparam logic [UOP_W-1:0] U_TGT_MOVE = 5'd10;
    localparam logic [UOP_W-1:0] U_RDCUR    = 5'd11;
    localparam logic [UOP_W-1:0] U_TGT_RD   = 5'd12;
    localparam logic [UOP_W-1:0] U_CURNIL   = 5'd13;
    localparam logic [UOP_W-1:0] U_CURON    = 5'd14;
    localparam logic [UOP_W-1:0] U_TAKE     = 5'd15;
    localparam logic [UOP_W-1:0] U_TGT_CUR  = 5'd16;
    localparam logic [UOP_W-1:0] U_PN_RD    = 5'd17;
    localparam logic [UOP_W-1:0] U_PN_HEAD  = 5'd18;
    localparam logic [UOP_W-1:0] U_RDK      = 5'd19;
    localparam logic [UOP_W-1:0] U_LINK1    = 5'd20;
    localparam logic [UOP_W-1:0] U_LINK2    = 5'd21;
    localparam logic [UOP_W-1:0] U_K_CUR    = 5'd22;
    localparam logic [UOP_W-1:0] U_K_LAST   = 5'd23;
    localparam logic [UOP_W-1:0] U_UNL1     = 5'd24;
    localparam logic [UOP_W-1:0] U_UNL2     = 5'd25;
    localparam logic [UOP_W-1:0] U_CAT      = 5'd26;
    localparam logic [UOP_W-1:0] U_FREE     = 5'd27;
    localparam logic [UOP_W-1:0] U_TGT_S0   = 5'd28;
    localparam logic [UOP_W-1:0] U_SRD      = 5'd29;
    localparam logic [UOP_W-1:0] U_FIN      = 5'd30;

    typedef struct packed {
        logic [UOP_W-1:0] uop;
    } plm_cmd_t;

    typedef struct packed {
        logic [3:0] op;
        logic       a_ok;
        logic       b_ok;
        logic       same;
        logic [1:0] cur_st;
        logic       node_pool_empty;
        logic       head_pool_empty;
        logic       tgt_nil;
        logic       match;
        logic       clr_last;
    } plm_stat_t;

endpackage

`default_nettype wire

/* src/plm_dp.sv */
// ----------------------------------------------------------------------------
// plm_dp: datapath of the pooled list manager
// Node memories (item, next link, prev link), list head registers, free
// chains, request/snapshot/work registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module plm_dp #(
    parameter int ITEM_WIDTH = 32
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  plm_pkg::plm_cmd_t     cmd,
    output plm_pkg::plm_stat_t    stat,
    input  wire  [3:0]            s_operation,
    input  wire  [3:0]            s_list_id,
    input  wire  [3:0]            s_other_list,
    input  wire  [ITEM_WIDTH-1:0] s_item_value,
    input  wire  [ITEM_WIDTH-1:0] s_search_key,
    output logic [ITEM_WIDTH-1:0] m_result_item,
    output logic                  m_has_item,
    output logic [1:0]            m_status,
    output logic [3:0]            m_new_list,
    output logic [6:0]            m_item_count
);
    import plm_pkg::*;

    localparam int NLW  = $clog2(NUM_NODES + 1);
    localparam int NIDX = $clog2(NUM_NODES);
    localparam int HLW  = $clog2(NUM_LISTS + 1);
    localparam int HIDX = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam logic [NLW-1:0] NIL_N = NLW'(NUM_NODES);
    localparam logic [HLW-1:0] NIL_H = HLW'(NUM_LISTS);

    // request
    logic [3:0]            req_op_reg, req_id_reg, req_other_reg;
    logic [ITEM_WIDTH-1:0] req_val_reg, req_key_reg;

    // list heads
    logic [NLW-1:0] head_first_reg [NUM_LISTS];
    logic [NLW-1:0] head_last_reg  [NUM_LISTS];
    logic [NLW-1:0] head_cur_reg   [NUM_LISTS];
    logic [NLW-1:0] head_len_reg   [NUM_LISTS];
    logic [1:0]     head_st_reg    [NUM_LISTS];
    logic [HLW-1:0] head_fnext_reg [NUM_LISTS];
    logic           head_used_reg  [NUM_LISTS];
    logic [HLW-1:0] free_head_top_reg;
    logic [NLW-1:0] free_node_top_reg;
    logic [NLW-1:0] clr_idx_reg;

    // snapshots of the two heads
    logic           a_ok_reg, b_ok_reg;
    logic [NLW-1:0] a_first_reg, a_last_reg, a_cur_reg, a_len_reg;
    logic [1:0]     a_st_reg;
    logic [NLW-1:0] b_first_reg, b_last_reg, b_len_reg;

    // work registers
    logic [NLW-1:0]        tgt_reg, p_reg, n_reg, k_reg;
    logic [ITEM_WIDTH-1:0] rd_item_reg;
    logic [NLW-1:0]        rd_next_reg, rd_prev_reg;

    // result
    logic [ITEM_WIDTH-1:0] r_item_reg;
    logic                  r_has_reg;
    logic [1:0]            r_status_reg;
    logic [3:0]            r_new_reg;
    logic [ITEM_WIDTH-1:0] m_item_reg;
    logic                  m_has_reg;
    logic [1:0]            m_status_reg;
    logic [3:0]            m_new_reg;
    logic [6:0]            m_count_reg;

    // node memories
    logic [ITEM_WIDTH-1:0] node_item_mem [NUM_NODES];
    logic [NLW-1:0]        node_next_mem [NUM_NODES];
    logic [NLW-1:0]        node_prev_mem [NUM_NODES];

    logic [HIDX-1:0] a_idx, b_idx, hsel, fh_idx;
    logic            a_in, b_in, hsel_in, hr_ok, fwd;
    logic [NLW-1:0]  hr_first, hr_last, hr_cur, hr_len, new_len;
    logic [1:0]      hr_st;
    logic [6:0]      count_out;

    logic            rd_en, nx_we, pv_we, it_we;
    logic [NLW-1:0]  rd_addr, nx_wa, nx_wd, pv_wa, pv_wd;

    // head read port
    assign a_idx   = HIDX'(req_id_reg);
    assign b_idx   = HIDX'(req_other_reg);
    assign a_in    = int'(req_id_reg) < NUM_LISTS;
    assign b_in    = int'(req_other_reg) < NUM_LISTS;
    assign hsel    = (cmd.uop == U_HEADB) ? b_idx : a_idx;
    assign hsel_in = (cmd.uop == U_HEADB) ? b_in : a_in;
    assign hr_ok   = hsel_in && head_used_reg[hsel];
    assign hr_first = head_first_reg[hsel];
    assign hr_last  = head_last_reg[hsel];
    assign hr_cur   = head_cur_reg[hsel];
    assign hr_len   = head_len_reg[hsel];
    assign hr_st    = head_st_reg[hsel];
    assign fh_idx   = free_head_top_reg[HIDX-1:0];
    assign fwd      = (req_op_reg != OP_PREV);
    assign new_len  = a_len_reg - NLW'(1);

    assign count_out = (req_op_reg != OP_CREATE && a_ok_reg &&
                        (req_op_reg != OP_CONCAT || b_ok_reg)) ? 7'(hr_len) : 7'd0;

    // status to controller
    always_comb begin
        stat.op              = req_op_reg;
        stat.a_ok            = a_ok_reg;
        stat.b_ok            = b_ok_reg;
        stat.same            = (req_id_reg == req_other_reg);
        stat.cur_st          = a_st_reg;
        stat.node_pool_empty = (free_node_top_reg == NIL_N);
        stat.head_pool_empty = (free_head_top_reg == NIL_H);
        stat.tgt_nil         = (tgt_reg == NIL_N);
        stat.match           = (rd_item_reg == req_key_reg);
        stat.clr_last        = (clr_idx_reg == NLW'(NUM_NODES - 1));
    end

    // node memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = a_cur_reg;
        nx_we   = 1'b0;
        nx_wa   = k_reg;
        nx_wd   = n_reg;
        pv_we   = 1'b0;
        pv_wa   = k_reg;
        pv_wd   = p_reg;
        it_we   = 1'b0;
        unique case (cmd.uop)
            U_CLR: begin
                nx_we = 1'b1;
                nx_wa = clr_idx_reg;
                nx_wd = clr_idx_reg + NLW'(1);
                pv_we = 1'b1;
                pv_wa = clr_idx_reg;
                pv_wd = NIL_N;
            end
            U_RDCUR, U_K_CUR: begin
                rd_en   = 1'b1;
                rd_addr = a_cur_reg;
            end
            U_K_LAST: begin
                rd_en   = 1'b1;
                rd_addr = a_last_reg;
            end
            U_CURON, U_SRD: begin
                rd_en   = 1'b1;
                rd_addr = tgt_reg;
            end
            U_RDK: begin
                rd_en   = 1'b1;
                rd_addr = free_node_top_reg;
            end
            U_LINK1: begin
                nx_we = 1'b1;
                pv_we = 1'b1;
                it_we = 1'b1;
            end
            U_LINK2: begin
                nx_we = (p_reg != NIL_N);
                nx_wa = p_reg;
                nx_wd = k_reg;
                pv_we = (n_reg != NIL_N);
                pv_wa = n_reg;
                pv_wd = k_reg;
            end
            U_UNL1: begin
                nx_we = (rd_prev_reg != NIL_N);
                nx_wa = rd_prev_reg;
                nx_wd = rd_next_reg;
                pv_we = (rd_next_reg != NIL_N);
                pv_wa = rd_next_reg;
                pv_wd = rd_prev_reg;
            end
            U_UNL2: begin
                nx_we = 1'b1;
                nx_wd = free_node_top_reg;
                pv_we = 1'b1;
                pv_wd = NIL_N;
            end
            U_CAT: begin
                nx_we = (a_len_reg != '0) && (b_len_reg != '0);
                nx_wa = a_last_reg;
                nx_wd = b_first_reg;
                pv_we = nx_we;
                pv_wa = b_first_reg;
                pv_wd = a_last_reg;
            end
            U_FREE: begin
                nx_we = (a_len_reg != '0);
                nx_wa = a_last_reg;
                nx_wd = free_node_top_reg;
            end
            default: begin
            end
        endcase
    end

    // node memories: one write port each, shared registered read
    always_ff @(posedge aclk) begin
        if (it_we) begin
            node_item_mem[k_reg[NIDX-1:0]] <= req_val_reg;
        end
        if (nx_we) begin
            node_next_mem[nx_wa[NIDX-1:0]] <= nx_wd;
        end
        if (pv_we) begin
            node_prev_mem[pv_wa[NIDX-1:0]] <= pv_wd;
        end
        if (rd_en) begin
            rd_item_reg <= node_item_mem[rd_addr[NIDX-1:0]];
            rd_next_reg <= node_next_mem[rd_addr[NIDX-1:0]];
            rd_prev_reg <= node_prev_mem[rd_addr[NIDX-1:0]];
        end
    end

    // list heads, free chains, clearing counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LISTS; i++) begin
                head_first_reg[i] <= NIL_N;
                head_last_reg[i]  <= NIL_N;
                head_cur_reg[i]   <= NIL_N;
                head_len_reg[i]   <= '0;
                head_st_reg[i]    <= CUR_EMPTY;
                head_used_reg[i]  <= 1'b0;
                head_fnext_reg[i] <= HLW'(i + 1);
            end
            free_head_top_reg <= '0;
            free_node_top_reg <= '0;
            clr_idx_reg       <= '0;
        end else begin
            unique case (cmd.uop)
                U_CLR: begin
                    clr_idx_reg <= clr_idx_reg + NLW'(1);
                end
                U_CREATE: begin
                    free_head_top_reg      <= head_fnext_reg[fh_idx];
                    head_fnext_reg[fh_idx] <= NIL_H;
                    head_first_reg[fh_idx] <= NIL_N;
                    head_last_reg[fh_idx]  <= NIL_N;
                    head_cur_reg[fh_idx]   <= NIL_N;
                    head_len_reg[fh_idx]   <= '0;
                    head_st_reg[fh_idx]    <= CUR_EMPTY;
                    head_used_reg[fh_idx]  <= 1'b1;
                end
                U_CURNIL: begin
                    head_cur_reg[a_idx] <= NIL_N;
                    head_st_reg[a_idx]  <= (req_op_reg == OP_PREV) ? CUR_BEFORE : CUR_PAST;
                end
                U_CURON: begin
                    head_cur_reg[a_idx] <= tgt_reg;
                    head_st_reg[a_idx]  <= CUR_ON;
                end
                U_LINK1: begin
                    free_node_top_reg <= rd_next_reg;
                end
                U_LINK2: begin
                    if (p_reg == NIL_N) begin
                        head_first_reg[a_idx] <= k_reg;
                    end
                    if (n_reg == NIL_N) begin
                        head_last_reg[a_idx] <= k_reg;
                    end
                    head_len_reg[a_idx] <= a_len_reg + NLW'(1);
                    head_cur_reg[a_idx] <= k_reg;
                    head_st_reg[a_idx]  <= CUR_ON;
                end
                U_UNL1: begin
                    if (rd_prev_reg == NIL_N) begin
                        head_first_reg[a_idx] <= rd_next_reg;
                    end
                    if (rd_next_reg == NIL_N) begin
                        head_last_reg[a_idx] <= rd_prev_reg;
                    end
                    head_len_reg[a_idx] <= new_len;
                    if (new_len == '0) begin
                        head_cur_reg[a_idx] <= NIL_N;
                        head_st_reg[a_idx]  <= CUR_EMPTY;
                    end else if (req_op_reg == OP_TRIM) begin
                        head_cur_reg[a_idx] <= rd_prev_reg;
                        head_st_reg[a_idx]  <= CUR_ON;
                    end else begin
                        head_cur_reg[a_idx] <= rd_next_reg;
                        head_st_reg[a_idx]  <= (rd_next_reg == NIL_N) ? CUR_PAST : CUR_ON;
                    end
                end
                U_UNL2: begin
                    free_node_top_reg <= k_reg;
                end
                U_CAT: begin
                    if (b_len_reg != '0) begin
                        if (a_len_reg == '0) begin
                            head_first_reg[a_idx] <= b_first_reg;
                            head_cur_reg[a_idx]   <= NIL_N;
                            head_st_reg[a_idx]    <= CUR_BEFORE;
                        end
                        head_last_reg[a_idx] <= b_last_reg;
                        head_len_reg[a_idx]  <= a_len_reg + b_len_reg;
                    end
                    // release the other head
                    head_first_reg[b_idx] <= NIL_N;
                    head_last_reg[b_idx]  <= NIL_N;
                    head_cur_reg[b_idx]   <= NIL_N;
                    head_len_reg[b_idx]   <= '0;
                    head_st_reg[b_idx]    <= CUR_EMPTY;
                    head_used_reg[b_idx]  <= 1'b0;
                    head_fnext_reg[b_idx] <= free_head_top_reg;
                    free_head_top_reg     <= HLW'(b_idx);
                end
                U_FREE: begin
                    if (a_len_reg != '0) begin
                        free_node_top_reg <= a_first_reg;
                    end
                    head_first_reg[a_idx] <= NIL_N;
                    head_last_reg[a_idx]  <= NIL_N;
                    head_cur_reg[a_idx]   <= NIL_N;
                    head_len_reg[a_idx]   <= '0;
                    head_st_reg[a_idx]    <= CUR_EMPTY;
                    head_used_reg[a_idx]  <= 1'b0;
                    head_fnext_reg[a_idx] <= free_head_top_reg;
                    free_head_top_reg     <= HLW'(a_idx);
                end
                default: begin
                end
            endcase
        end
    end

    // request, snapshots, work and result registers
    always_ff @(posedge aclk) begin
        unique case (cmd.uop)
            U_LOAD: begin
                req_op_reg    <= s_operation;
                req_id_reg    <= s_list_id;
                req_other_reg <= s_other_list;
                req_val_reg   <= s_item_value;
                req_key_reg   <= s_search_key;
                r_item_reg    <= '0;
                r_has_reg     <= 1'b0;
                r_status_reg  <= ST_OK;
                r_new_reg     <= 4'd0;
            end
            U_HEADA: begin
                a_ok_reg    <= hr_ok;
                a_first_reg <= hr_first;
                a_last_reg  <= hr_last;
                a_cur_reg   <= hr_cur;
                a_len_reg   <= hr_len;
                a_st_reg    <= hr_st;
            end
            U_HEADB: begin
                b_ok_reg    <= hr_ok;
                b_first_reg <= hr_first;
                b_last_reg  <= hr_last;
                b_len_reg   <= hr_len;
            end
            U_ST1, U_CURNIL: begin
                r_status_reg <= ST_NO_ITEM;
            end
            U_ST2: begin
                r_status_reg <= ST_POOL_FULL;
            end
            U_ST3: begin
                r_status_reg <= ST_NO_HEAD;
            end
            U_CREATE: begin
                r_new_reg <= 4'(free_head_top_reg);
            end
            U_TGT_END: begin
                tgt_reg <= (req_op_reg == OP_FIRST) ? a_first_reg : a_last_reg;
            end
            U_TGT_MOVE: begin
                if (a_st_reg == CUR_BEFORE) begin
                    tgt_reg <= fwd ? a_first_reg : NIL_N;
                end else begin
                    tgt_reg <= fwd ? NIL_N : a_last_reg;
                end
            end
            U_TGT_RD: begin
                tgt_reg <= fwd ? rd_next_reg : rd_prev_reg;
            end
            U_TGT_CUR: begin
                tgt_reg <= a_cur_reg;
            end
            U_TGT_S0: begin
                tgt_reg <= (a_st_reg == CUR_BEFORE) ? a_first_reg : a_cur_reg;
            end
            U_TAKE, U_UNL1: begin
                r_item_reg <= rd_item_reg;
                r_has_reg  <= 1'b1;
            end
            U_PN_RD: begin
                if (req_op_reg == OP_INS_AFTER) begin
                    p_reg <= a_cur_reg;
                    n_reg <= rd_next_reg;
                end else begin
                    p_reg <= rd_prev_reg;
                    n_reg <= a_cur_reg;
                end
            end
            U_PN_HEAD: begin
                if (req_op_reg == OP_PREPEND || (req_op_reg != OP_APPEND &&
                    (a_st_reg == CUR_BEFORE ||
                     (a_st_reg == CUR_EMPTY && req_op_reg == OP_INS_BEFORE)))) begin
                    p_reg <= NIL_N;
                    n_reg <= a_first_reg;
                end else begin
                    p_reg <= a_last_reg;
                    n_reg <= NIL_N;
                end
            end
            U_RDK: begin
                k_reg <= free_node_top_reg;
            end
            U_K_CUR: begin
                k_reg <= a_cur_reg;
            end
            U_K_LAST: begin
                k_reg <= a_last_reg;
            end
            U_FIN: begin
                m_item_reg   <= r_item_reg;
                m_has_reg    <= r_has_reg;
                m_status_reg <= r_status_reg;
                m_new_reg    <= r_new_reg;
                m_count_reg  <= count_out;
            end
            default: begin
            end
        endcase
    end

    assign m_result_item = m_item_reg;
    assign m_has_item    = m_has_reg;
    assign m_status      = m_status_reg;
    assign m_new_list    = m_new_reg;
    assign m_item_count  = m_count_reg;

    // free node pointer is a node or null
    assert property (@(posedge aclk) disable iff (!aresetn)
        free_node_top_reg <= NIL_N)
        else $error("free node pointer out of range");

    // a node is only taken from a non-empty pool
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.uop == U_LINK1) |-> (free_node_top_reg != NIL_N))
        else $error("node taken from empty pool");

    // the node being linked in is a real node
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.uop == U_LINK2) |-> (k_reg != NIL_N))
        else $error("null node linked");

endmodule

`default_nettype wire

/* src/plm_ctrl.sv */
// ----------------------------------------------------------------------------
// plm_ctrl: controller of the pooled list manager
// Sequences the datapath micro-ops for each request, runs the link clearing
// pass after reset and owns the request/result handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module plm_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire                 m_ready,
    output plm_pkg::plm_cmd_t   cmd,
    input  plm_pkg::plm_stat_t  stat
);
    import plm_pkg::*;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_HA    = 5'd2;
    localparam logic [4:0] S_HB    = 5'd3;
    localparam logic [4:0] S_DISP  = 5'd4;
    localparam logic [4:0] S_MOVE  = 5'd5;
    localparam logic [4:0] S_CHK   = 5'd6;
    localparam logic [4:0] S_GOTGT = 5'd7;
    localparam logic [4:0] S_TAKE  = 5'd8;
    localparam logic [4:0] S_PN    = 5'd9;
    localparam logic [4:0] S_POPK  = 5'd10;
    localparam logic [4:0] S_LINK1 = 5'd11;
    localparam logic [4:0] S_LINK2 = 5'd12;
    localparam logic [4:0] S_UNL1  = 5'd13;
    localparam logic [4:0] S_UNL2  = 5'd14;
    localparam logic [4:0] S_SRD   = 5'd15;
    localparam logic [4:0] S_SCMP  = 5'd16;
    localparam logic [4:0] S_FIN   = 5'd17;

    logic [4:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    // next state and micro-op
    always_comb begin
        state_next = state_reg;
        cmd.uop    = U_NOP;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_CLR: begin
                cmd.uop = U_CLR;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.uop    = U_LOAD;
                    state_next = S_HA;
                end
            end
            S_HA: begin
                cmd.uop    = U_HEADA;
                state_next = S_HB;
            end
            S_HB: begin
                cmd.uop    = U_HEADB;
                state_next = S_DISP;
            end
            S_DISP: begin
                state_next = S_FIN;
                if (stat.op == OP_CREATE) begin
                    cmd.uop = stat.head_pool_empty ? U_ST3 : U_CREATE;
                end else if (!stat.a_ok || (stat.op == OP_CONCAT && !stat.b_ok)) begin
                    cmd.uop = U_ST1;
                end else begin
                    unique case (stat.op) inside
                        OP_FIRST, OP_LAST: begin
                            if (stat.cur_st == CUR_EMPTY) begin
                                cmd.uop = U_ST1;
                            end else begin
                                cmd.uop    = U_TGT_END;
                                state_next = S_GOTGT;
                            end
                        end
                        OP_NEXT, OP_PREV: begin
                            if (stat.cur_st == CUR_EMPTY) begin
                                cmd.uop = U_ST1;
                            end else if (stat.cur_st == CUR_ON) begin
                                cmd.uop    = U_RDCUR;
                                state_next = S_MOVE;
                            end else begin
                                cmd.uop    = U_TGT_MOVE;
                                state_next = S_CHK;
                            end
                        end
                        OP_CURRENT: begin
                            if (stat.cur_st == CUR_ON) begin
                                cmd.uop    = U_TGT_CUR;
                                state_next = S_GOTGT;
                            end else begin
                                cmd.uop = U_ST1;
                            end
                        end
                        OP_INS_AFTER, OP_INS_BEFORE, OP_APPEND, OP_PREPEND: begin
                            if (stat.node_pool_empty) begin
                                cmd.uop = U_ST2;
                            end else if ((stat.op == OP_INS_AFTER ||
                                          stat.op == OP_INS_BEFORE) &&
                                         stat.cur_st == CUR_ON) begin
                                cmd.uop    = U_RDCUR;
                                state_next = S_PN;
                            end else begin
                                cmd.uop    = U_PN_HEAD;
                                state_next = S_POPK;
                            end
                        end
                        OP_REMOVE: begin
                            if (stat.cur_st == CUR_ON) begin
                                cmd.uop    = U_K_CUR;
                                state_next = S_UNL1;
                            end else begin
                                cmd.uop = U_ST1;
                            end
                        end
                        OP_TRIM: begin
                            if (stat.cur_st == CUR_EMPTY) begin
                                cmd.uop = U_ST1;
                            end else begin
                                cmd.uop    = U_K_LAST;
                                state_next = S_UNL1;
                            end
                        end
                        OP_CONCAT: begin
                            cmd.uop = stat.same ? U_NOP : U_CAT;
                        end
                        OP_FREE: begin
                            cmd.uop = U_FREE;
                        end
                        OP_SEARCH: begin
                            if (stat.cur_st == CUR_EMPTY || stat.cur_st == CUR_PAST) begin
                                cmd.uop = U_ST1;
                            end else begin
                                cmd.uop    = U_TGT_S0;
                                state_next = S_SRD;
                            end
                        end
                        default: begin
                            cmd.uop = U_NOP;
                        end
                    endcase
                end
            end
            S_MOVE: begin
                cmd.uop    = U_TGT_RD;
                state_next = S_CHK;
            end
            S_CHK: begin
                if (stat.tgt_nil) begin
                    cmd.uop    = U_CURNIL;
                    state_next = S_FIN;
                end else begin
                    state_next = S_GOTGT;
                end
            end
            S_GOTGT: begin
                cmd.uop    = U_CURON;
                state_next = S_TAKE;
            end
            S_TAKE: begin
                cmd.uop    = U_TAKE;
                state_next = S_FIN;
            end
            S_PN: begin
                cmd.uop    = U_PN_RD;
                state_next = S_POPK;
            end
            S_POPK: begin
                cmd.uop    = U_RDK;
                state_next = S_LINK1;
            end
            S_LINK1: begin
                cmd.uop    = U_LINK1;
                state_next = S_LINK2;
            end
            S_LINK2: begin
                cmd.uop    = U_LINK2;
                state_next = S_FIN;
            end
            S_UNL1: begin
                cmd.uop    = U_UNL1;
                state_next = S_UNL2;
            end
            S_UNL2: begin
                cmd.uop    = U_UNL2;
                state_next = S_FIN;
            end
            S_SRD: begin
                if (stat.tgt_nil) begin
                    cmd.uop    = U_CURNIL;
                    state_next = S_FIN;
                end else begin
                    cmd.uop    = U_SRD;
                    state_next = S_SCMP;
                end
            end
            S_SCMP: begin
                if (stat.match) begin
                    state_next = S_GOTGT;
                end else begin
                    cmd.uop    = U_TGT_RD;
                    state_next = S_SRD;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.uop    = U_FIN;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result slot
    always_comb begin
        if (cmd.uop == U_FIN) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    // an accepted request starts with the head fetch
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_HA))
        else $error("request not followed by head fetch");

    // a result is only written into a free or draining slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.uop == U_FIN) |-> (!m_valid_reg || m_ready))
        else $error("result overwritten");

    // a finished request shows its result next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.uop == U_FIN) |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("result not presented");

endmodule

`default_nettype wire

/* src/pooled_list_manager_unit.sv */
// ----------------------------------------------------------------------------
// pooled_list_manager_unit: doubly linked lists over a shared node pool
// Top level: controller plus datapath.
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass over all NUM_NODES node links,
// during which s_ready stays low. It then takes one request at a time; the
// time per request is set by the dependent accesses to the node link
// memories (one registered read port) and the head fetch, and a search
// takes longer the more nodes it visits. A finished result sits in an
// output register, so a new request is accepted while the result waits
// for m_ready.
`default_nettype none

module pooled_list_manager_unit #(
    parameter int ITEM_WIDTH = 32
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire  [3:0]            s_operation,
    input  wire  [3:0]            s_list_id,
    input  wire  [3:0]            s_other_list,
    input  wire  [ITEM_WIDTH-1:0] s_item_value,
    input  wire  [ITEM_WIDTH-1:0] s_search_key,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic [ITEM_WIDTH-1:0] m_result_item,
    output logic                  m_has_item,
    output logic [1:0]            m_status,
    output logic [3:0]            m_new_list,
    output logic [6:0]            m_item_count
);
    import plm_pkg::*;

    plm_cmd_t  cmd;
    plm_stat_t stat;

    // sequencer
    plm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // storage and result
    plm_dp #(
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_operation   (s_operation),
        .s_list_id     (s_list_id),
        .s_other_list  (s_other_list),
        .s_item_value  (s_item_value),
        .s_search_key  (s_search_key),
        .m_result_item (m_result_item),
        .m_has_item    (m_has_item),
        .m_status      (m_status),
        .m_new_list    (m_new_list),
        .m_item_count  (m_item_count)
    );

endmodule

`default_nettype wire

/* bench/pooled_list_manager_unit_tb.sv */
// ----------------------------------------------------------------------------
// pooled_list_manager_unit_tb: self-checking bench for the pooled list manager
// A directed opener walks every operation and corner (empty lists, cursor
// ends, bad handles), then random requests are aimed mostly at live lists,
// with runs that drain the head and node pools. Each request's answer is
// predicted when the request is built. Answers are checked in order as they
// leave the block, with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module pooled_list_manager_unit_tb;
    import plm_pkg::*;

    localparam int NODES   = 64;
    localparam int LISTS   = 16;
    localparam int NIL_N   = NODES;
    localparam int NIL_H   = LISTS;
    localparam int N_RAND  = 1170;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] item;
        logic        has;
        logic [3:0]  newl;
        logic [6:0]  cnt;
    } answer_t;

    typedef struct {
        logic [3:0]  op;
        logic [3:0]  id;
        logic [3:0]  other;
        logic [31:0] val;
        logic [31:0] key;
        bit          hold;
        answer_t     ans;
    } request_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    wire         s_ready;
    logic [3:0]  s_operation = '0;
    logic [3:0]  s_list_id = '0;
    logic [3:0]  s_other_list = '0;
    logic [31:0] s_item_value = '0;
    logic [31:0] s_search_key = '0;
    wire         m_valid;
    logic        m_ready = 1'b0;
    wire  [31:0] m_result_item;
    wire         m_has_item;
    wire  [1:0]  m_status;
    wire  [3:0]  m_new_list;
    wire  [6:0]  m_item_count;

    pooled_list_manager_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .s_list_id(s_list_id),
        .s_other_list(s_other_list), .s_item_value(s_item_value),
        .s_search_key(s_search_key),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_item(m_result_item), .m_has_item(m_has_item),
        .m_status(m_status), .m_new_list(m_new_list),
        .m_item_count(m_item_count)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // shadow of the node pool and list heads
    logic [31:0] nitem [NODES];
    int          nnext [NODES];
    int          nprev [NODES];
    int          free_node, nodes_used;
    int          hfirst [LISTS];
    int          hlast [LISTS];
    int          hcur [LISTS];
    int          hlen [LISTS];
    logic [1:0]  hstate [LISTS];
    int          hfree [LISTS];
    bit          in_use [LISTS];
    int          free_head;

    request_t pending_requests[$];
    answer_t  answers_due[$];
    int       mismatches = 0;

    function automatic void clear_head(int h);
        hfirst[h] = NIL_N;
        hlast[h]  = NIL_N;
        hcur[h]   = NIL_N;
        hlen[h]   = 0;
        hstate[h] = CUR_EMPTY;
    endfunction

    function automatic void release_head(int h);
        clear_head(h);
        in_use[h] = 0;
        hfree[h] = free_head;
        free_head = h;
    endfunction

    function automatic void link_node(int h, int p, int n, logic [31:0] v);
        int k;
        k = free_node;
        free_node = nnext[k];
        nodes_used++;
        nitem[k] = v;
        nprev[k] = p;
        nnext[k] = n;
        if (p == NIL_N) hfirst[h] = k; else nnext[p] = k;
        if (n == NIL_N) hlast[h] = k; else nprev[n] = k;
        hlen[h]++;
        hcur[h] = k;
        hstate[h] = CUR_ON;
    endfunction

    function automatic logic [31:0] unlink_node(int h, int k);
        int p, n;
        p = nprev[k];
        n = nnext[k];
        if (p == NIL_N) hfirst[h] = n; else nnext[p] = n;
        if (n == NIL_N) hlast[h] = p; else nprev[n] = p;
        hlen[h]--;
        nnext[k] = free_node;
        nprev[k] = NIL_N;
        free_node = k;
        nodes_used--;
        return nitem[k];
    endfunction

    // predicted answer of one request; updates the shadow state
    function automatic answer_t list_op_answer(request_t r);
        answer_t    a;
        int         h, g, cur, p, n, nx;
        logic [1:0] st;
        bit         fwd;
        a = '{default: '0};
        h = r.id;
        g = r.other;
        if (r.op == OP_CREATE) begin
            if (free_head == NIL_H) begin
                a.status = ST_NO_HEAD;
            end else begin
                h = free_head;
                free_head = hfree[h];
                hfree[h] = NIL_H;
                clear_head(h);
                in_use[h] = 1;
                a.newl = 4'(h);
            end
            return a;
        end
        if (!in_use[h] || (r.op == OP_CONCAT && !in_use[g])) begin
            a.status = ST_NO_ITEM;
            return a;
        end
        st = hstate[h];
        cur = hcur[h];
        case (r.op)
            OP_FIRST, OP_LAST: begin
                if (st == CUR_EMPTY) begin
                    a.status = ST_NO_ITEM;
                end else begin
                    cur = (r.op == OP_FIRST) ? hfirst[h] : hlast[h];
                    hcur[h] = cur;
                    hstate[h] = CUR_ON;
                    a.item = nitem[cur];
                    a.has = 1;
                end
            end
            OP_NEXT, OP_PREV: begin
                fwd = (r.op == OP_NEXT);
                if (st == CUR_EMPTY) begin
                    a.status = ST_NO_ITEM;
                end else begin
                    if (st == CUR_ON) cur = fwd ? nnext[cur] : nprev[cur];
                    else if (st == CUR_BEFORE) cur = fwd ? hfirst[h] : NIL_N;
                    else cur = fwd ? NIL_N : hlast[h];
                    if (cur == NIL_N) begin
                        hcur[h] = NIL_N;
                        hstate[h] = fwd ? CUR_PAST : CUR_BEFORE;
                        a.status = ST_NO_ITEM;
                    end else begin
                        hcur[h] = cur;
                        hstate[h] = CUR_ON;
                        a.item = nitem[cur];
                        a.has = 1;
                    end
                end
            end
            OP_CURRENT: begin
                if (st == CUR_ON) begin
                    a.item = nitem[cur];
                    a.has = 1;
                end else begin
                    a.status = ST_NO_ITEM;
                end
            end
            OP_INS_AFTER, OP_INS_BEFORE, OP_APPEND, OP_PREPEND: begin
                if (free_node == NIL_N) begin
                    a.status = ST_POOL_FULL;
                end else begin
                    if (r.op == OP_APPEND) begin
                        p = hlast[h]; n = NIL_N;
                    end else if (r.op == OP_PREPEND) begin
                        p = NIL_N; n = hfirst[h];
                    end else if (st == CUR_ON) begin
                        if (r.op == OP_INS_AFTER) begin
                            p = cur; n = nnext[cur];
                        end else begin
                            p = nprev[cur]; n = cur;
                        end
                    end else if (st == CUR_BEFORE ||
                                 (st == CUR_EMPTY && r.op == OP_INS_BEFORE)) begin
                        p = NIL_N; n = hfirst[h];
                    end else begin
                        p = hlast[h]; n = NIL_N;
                    end
                    link_node(h, p, n, r.val);
                end
            end
            OP_REMOVE: begin
                if (st != CUR_ON) begin
                    a.status = ST_NO_ITEM;
                end else begin
                    nx = nnext[cur];
                    a.item = unlink_node(h, cur);
                    a.has = 1;
                    hcur[h] = nx;
                    if (hlen[h] == 0) begin
                        hcur[h] = NIL_N;
                        hstate[h] = CUR_EMPTY;
                    end else if (nx == NIL_N) begin
                        hstate[h] = CUR_PAST;
                    end else begin
                        hstate[h] = CUR_ON;
                    end
                end
            end
            OP_TRIM: begin
                if (st == CUR_EMPTY) begin
                    a.status = ST_NO_ITEM;
                end else begin
                    a.item = unlink_node(h, hlast[h]);
                    a.has = 1;
                    if (hlen[h] == 0) begin
                        hcur[h] = NIL_N;
                        hstate[h] = CUR_EMPTY;
                    end else begin
                        hcur[h] = hlast[h];
                        hstate[h] = CUR_ON;
                    end
                end
            end
            OP_CONCAT: begin
                if (g != h) begin
                    if (hlen[g] != 0) begin
                        if (hlen[h] == 0) begin
                            hfirst[h] = hfirst[g];
                            hcur[h] = NIL_N;
                            hstate[h] = CUR_BEFORE;
                        end else begin
                            nnext[hlast[h]] = hfirst[g];
                            nprev[hfirst[g]] = hlast[h];
                        end
                        hlast[h] = hlast[g];
                        hlen[h] += hlen[g];
                    end
                    release_head(g);
                end
            end
            OP_FREE: begin
                if (hlen[h] != 0) begin
                    nnext[hlast[h]] = free_node;
                    free_node = hfirst[h];
                    nodes_used -= hlen[h];
                end
                release_head(h);
            end
            OP_SEARCH: begin
                if (st == CUR_EMPTY || st == CUR_PAST) begin
                    a.status = ST_NO_ITEM;
                end else begin
                    if (st == CUR_BEFORE) cur = hfirst[h];
                    while (cur != NIL_N && nitem[cur] != r.key) cur = nnext[cur];
                    if (cur == NIL_N) begin
                        hcur[h] = NIL_N;
                        hstate[h] = CUR_PAST;
                        a.status = ST_NO_ITEM;
                    end else begin
                        hcur[h] = cur;
                        hstate[h] = CUR_ON;
                        a.item = nitem[cur];
                        a.has = 1;
                    end
                end
            end
            default: ;
        endcase
        a.cnt = 7'(hlen[h]);
        return a;
    endfunction

    // predict and queue one request; returns the handle a create gave out
    function automatic int add_request(logic [3:0] op, int id, int other,
                                       logic [31:0] val, logic [31:0] key,
                                       bit hold = 0);
        request_t r;
        r.op = op;
        r.id = 4'(id);
        r.other = 4'(other);
        r.val = val;
        r.key = key;
        r.hold = hold;
        r.ans = list_op_answer(r);
        pending_requests.push_back(r);
        return (r.ans.status == ST_OK) ? int'(r.ans.newl) : -1;
    endfunction

    // random live handle, or -1 when none is live
    function automatic int pick_live();
        int live[$];
        for (int i = 0; i < LISTS; i++) if (in_use[i]) live.push_back(i);
        if (live.size() == 0) return -1;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    // search key: often an item already in the list
    function automatic logic [31:0] pick_key(int h);
        logic [31:0] vals[$];
        int k;
        k = hfirst[h];
        while (k != NIL_N) begin
            vals.push_back(nitem[k]);
            k = nnext[k];
        end
        if (vals.size() == 0 || $urandom_range(0, 2) == 0) return $urandom;
        return vals[$urandom_range(0, vals.size() - 1)];
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    // stimulus
    initial begin
        int a, b, h, r;
        logic [3:0] op;
        for (int i = 0; i < NODES; i++) begin
            nitem[i] = '0;
            nnext[i] = i + 1;
            nprev[i] = NIL_N;
        end
        free_node = 0;
        nodes_used = 0;
        for (int i = 0; i < LISTS; i++) begin
            clear_head(i);
            in_use[i] = 0;
            hfree[i] = i + 1;
        end
        free_head = 0;

        // directed opener
        a = add_request(OP_CREATE, 0, 0, 0, 0);
        void'(add_request(OP_COUNT, 15, 0, 0, 0));
        void'(add_request(OP_FIRST, a, 0, 0, 0));
        void'(add_request(OP_NEXT, a, 0, 0, 0));
        void'(add_request(OP_SEARCH, a, 0, 0, 0));
        void'(add_request(OP_INS_AFTER, a, 0, 32'hFFFF_FFFF, 0));
        void'(add_request(OP_TRIM, a, 0, 0, 0));
        void'(add_request(OP_INS_BEFORE, a, 0, 32'h0, 0));
        void'(add_request(OP_APPEND, a, 0, 32'hA5A5_5A5A, 0));
        void'(add_request(OP_PREPEND, a, 0, 32'h5A5A_A5A5, 0));
        void'(add_request(OP_LAST, a, 0, 0, 0));
        void'(add_request(OP_NEXT, a, 0, 0, 0));
        void'(add_request(OP_NEXT, a, 0, 0, 0));
        void'(add_request(OP_INS_BEFORE, a, 0, 32'h1234_5678, 0));
        void'(add_request(OP_FIRST, a, 0, 0, 0));
        void'(add_request(OP_PREV, a, 0, 0, 0));
        void'(add_request(OP_PREV, a, 0, 0, 0));
        void'(add_request(OP_INS_AFTER, a, 0, 32'h8000_0001, 0));
        void'(add_request(OP_CURRENT, a, 0, 0, 0));
        void'(add_request(OP_SEARCH, a, 0, 0, 32'hA5A5_5A5A));
        void'(add_request(OP_SEARCH, a, 0, 0, 32'hDEAD_BEEF));
        void'(add_request(OP_REMOVE, a, 0, 0, 0));
        b = add_request(OP_CREATE, 0, 0, 0, 0);
        void'(add_request(OP_CONCAT, a, a, 0, 0));
        void'(add_request(OP_CONCAT, b, a, 0, 0));
        void'(add_request(OP_CONCAT, b, 9, 0, 0));
        void'(add_request(OP_FREE, b, 0, 0, 0));

        // random part: mostly live handles, some noise, a few fill runs
        for (int i = 0; i < N_RAND; i++) begin
            if (i == 300 || i == 900) begin
                h = add_request(OP_CREATE, 0, 0, 0, 0, 1);
                if (h < 0) h = pick_live();
                for (int j = 0; j < NODES + 2; j++)
                    void'(add_request(OP_APPEND, h, 0, pick_value(), 0));
                void'(add_request(OP_FREE, h, 0, 0, 0));
            end
            if (i == 600) begin
                for (int j = 0; j < LISTS + 1; j++)
                    void'(add_request(OP_CREATE, 0, 0, 0, 0));
            end
            r = $urandom_range(0, 99);
            h = pick_live();
            if (r < 6) begin
                void'(add_request(4'($urandom_range(0, 15)), $urandom_range(0, 15),
                                  $urandom_range(0, 15), $urandom, $urandom));
                continue;
            end
            if (h < 0 || r < 11) begin
                void'(add_request(OP_CREATE, $urandom_range(0, 15), 0, 0, 0));
                continue;
            end
            if (r < 45) op = 4'(OP_INS_AFTER + $urandom_range(0, 3));
            else op = 4'($urandom_range(1, 15));
            if (nodes_used > 56 && $urandom_range(0, 1)) op = OP_TRIM;
            if (op == OP_FREE && $urandom_range(0, 1)) op = OP_COUNT;
            b = ($urandom_range(0, 7) == 0) ? h : pick_live();
            void'(add_request(op, h, b, pick_value(), pick_key(h)));
        end
    end

    // reset
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // request driver: bursts with random gaps
    int  burst_left = 1;
    int  gap_left = 0;
    answer_t on_bus;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) answers_due.push_back(on_bus);
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_requests.size() > 0 &&
                         (!pending_requests[0].hold || answers_due.size() == 0)) begin
                s_valid      <= 1'b1;
                s_operation  <= pending_requests[0].op;
                s_list_id    <= pending_requests[0].id;
                s_other_list <= pending_requests[0].other;
                s_item_value <= pending_requests[0].val;
                s_search_key <= pending_requests[0].key;
                on_bus = pending_requests[0].ans;
                void'(pending_requests.pop_front());
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // answer checker and receiver stalls
    int stall_mode = 0;
    int cyc = 0;

    always @(posedge aclk) begin
        answer_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected answer, nothing pending");
                end else begin
                    e = answers_due.pop_front();
                    if (m_result_item !== e.item || m_has_item !== e.has ||
                        m_status !== e.status || m_new_list !== e.newl ||
                        m_item_count !== e.cnt) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp item=%h has=%b st=%0d new=%0d cnt=%0d",
                                     e.item, e.has, e.status, e.newl, e.cnt,
                                     " got item=%h has=%b st=%0d new=%0d cnt=%0d",
                                     m_result_item, m_has_item, m_status,
                                     m_new_list, m_item_count);
                    end
                end
            end
            cyc <= cyc + 1;
            if (cyc % 300 == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= (cyc % 9) > 5;
            endcase
        end
    end

    // watchdog: cycles with no handshake on either side
    int quiet = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > STALL_LIMIT) begin
            $display("FAIL pooled_list_manager_unit");
            $finish;
        end
    end

    // end of run
    initial begin
        @(posedge aresetn);
        @(posedge aclk);
        while (pending_requests.size() > 0 || s_valid || answers_due.size() > 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS pooled_list_manager_unit");
        end else begin
            $display("FAIL pooled_list_manager_unit");
        end
        $finish;
    end

endmodule

`default_nettype wire
